// ===== hdl/rfe_pkg.sv =====
// rfe_pkg: shared types and constants for the pulse frame encoder.
// Holds the item structs, the register set struct and the register indexes.
// Depends on nothing.
package rfe_pkg;

    localparam int unsigned ID_FIELD_W   = 26;
    localparam int unsigned UNIT_FIELD_W = 4;
    localparam int unsigned COUNT_W      = 8;
    localparam int unsigned TICK_W       = 16;
    localparam int unsigned CFG_IDX_W    = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_PULSE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_ONE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_ZERO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_LONG  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SHORT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_END_LOW    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_GAP = 3'd6;

    // register reset values
    localparam logic [TICK_W-1:0] RST_HIGH_PULSE = 16'd310;
    localparam logic [TICK_W-1:0] RST_LOW_ONE    = 16'd1340;
    localparam logic [TICK_W-1:0] RST_LOW_ZERO   = 16'd310;
    localparam logic [TICK_W-1:0] RST_SYNC_LONG  = 16'd9900;
    localparam logic [TICK_W-1:0] RST_SYNC_SHORT = 16'd2675;
    localparam logic [TICK_W-1:0] RST_END_LOW    = 16'd2675;
    localparam logic [TICK_W-1:0] RST_REPEAT_GAP = 16'd10000;

    // func codes
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_START = 1'b1;

    typedef struct packed {
        logic                    func;
        logic [ID_FIELD_W-1:0]   emitter_id;
        logic                    group_flag;
        logic                    turn_on;
        logic [UNIT_FIELD_W-1:0] unit_code;
        logic [COUNT_W-1:0]      repeat_count;
    } t_in_item;

    typedef struct packed {
        logic pin_level;
        logic busy_res;
    } t_out_item;

    typedef struct packed {
        logic [TICK_W-1:0] high_pulse_ticks;
        logic [TICK_W-1:0] low_one_ticks;
        logic [TICK_W-1:0] low_zero_ticks;
        logic [TICK_W-1:0] sync_long_ticks;
        logic [TICK_W-1:0] sync_short_ticks;
        logic [TICK_W-1:0] end_low_ticks;
        logic [TICK_W-1:0] repeat_gap_ticks;
    } t_cfg;

endpackage

// ===== hdl/rfe_cfg_regs.sv =====
// rfe_cfg_regs: configuration register set of the pulse frame encoder.
// Depends on rfe_pkg.
module rfe_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [rfe_pkg::CFG_IDX_W-1:0] i_wr_index,
    input  logic [rfe_pkg::TICK_W-1:0]    i_wr_data,
    output rfe_pkg::t_cfg                 o_cfg
);
    import rfe_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.high_pulse_ticks <= RST_HIGH_PULSE;
            r_cfg.low_one_ticks    <= RST_LOW_ONE;
            r_cfg.low_zero_ticks   <= RST_LOW_ZERO;
            r_cfg.sync_long_ticks  <= RST_SYNC_LONG;
            r_cfg.sync_short_ticks <= RST_SYNC_SHORT;
            r_cfg.end_low_ticks    <= RST_END_LOW;
            r_cfg.repeat_gap_ticks <= RST_REPEAT_GAP;
        end else if (i_wr_en) begin
            // drop writes beyond the register list
            unique case (i_wr_index)
                CFG_HIGH_PULSE: r_cfg.high_pulse_ticks <= i_wr_data;
                CFG_LOW_ONE:    r_cfg.low_one_ticks    <= i_wr_data;
                CFG_LOW_ZERO:   r_cfg.low_zero_ticks   <= i_wr_data;
                CFG_SYNC_LONG:  r_cfg.sync_long_ticks  <= i_wr_data;
                CFG_SYNC_SHORT: r_cfg.sync_short_ticks <= i_wr_data;
                CFG_END_LOW:    r_cfg.end_low_ticks    <= i_wr_data;
                CFG_REPEAT_GAP: r_cfg.repeat_gap_ticks <= i_wr_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/rfe_seq.sv =====
// rfe_seq: frame sequencer, one item per step, with the result register.
// Depends on rfe_pkg.
module rfe_seq #(
    parameter int unsigned ID_BITS   = 26,
    parameter int unsigned UNIT_BITS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  rfe_pkg::t_in_item  i_item,
    input  rfe_pkg::t_cfg      i_cfg,
    output rfe_pkg::t_out_item o_res
);
    import rfe_pkg::*;

    localparam int unsigned FRAME_BITS = ID_BITS + 2 + UNIT_BITS;
    localparam int unsigned BIX_W      = $clog2(FRAME_BITS + 1);
    localparam int unsigned IDX_W      = $clog2(FRAME_BITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SYNC_LONG,
        S_SYNC_SHORT,
        S_DATA,
        S_CLOSE,
        S_GAP
    } t_phase;

    t_phase                  r_phase,      n_phase;
    logic [FRAME_BITS-1:0]   r_frame,      n_frame;
    logic [BIX_W-1:0]        r_bit_idx,    n_bit_idx;
    logic                    r_raw_half,   n_raw_half;
    logic                    r_pulse_high, n_pulse_high;
    logic [TICK_W-1:0]       r_tick,       n_tick;
    logic [COUNT_W-1:0]      r_repeats,    n_repeats;
    logic                    r_level,      n_level;
    t_out_item               r_res,        n_res;

    logic [FRAME_BITS-1:0]   load_frame;
    logic [31:0]             id_ext;
    logic [7:0]              unit_ext;
    logic [TICK_W-1:0]       tick_inc;
    logic [TICK_W-1:0]       seg_len;
    logic                    raw_bit;
    logic [BIX_W-1:0]        bit_inc;
    logic [COUNT_W-1:0]      rep_dec;

    // assemble the frame: id LSB first, group, on/off, unit LSB first
    always_comb begin
        id_ext   = {{(32 - ID_FIELD_W){1'b0}}, i_item.emitter_id};
        unit_ext = {{(8 - UNIT_FIELD_W){1'b0}}, i_item.unit_code};
        for (int k = 0; k < FRAME_BITS; k++) begin
            if (k < ID_BITS) begin
                load_frame[k] = id_ext[5'(k)];
            end else if (k == ID_BITS) begin
                load_frame[k] = i_item.group_flag;
            end else if (k == ID_BITS + 1) begin
                load_frame[k] = i_item.turn_on;
            end else begin
                load_frame[k] = unit_ext[3'(k - ID_BITS - 2)];
            end
        end
    end

    assign raw_bit  = r_frame[r_bit_idx[IDX_W-1:0]] ^ r_raw_half;
    assign tick_inc = r_tick + 1'b1;
    assign bit_inc  = r_bit_idx + 1'b1;
    assign rep_dec  = r_repeats - 1'b1;

    // a zero length still ends after one tick, since tick_inc is at least one
    always_comb begin
        if (r_pulse_high) begin
            seg_len = i_cfg.high_pulse_ticks;
        end else begin
            case (r_phase)
                S_SYNC_LONG:  seg_len = i_cfg.sync_long_ticks;
                S_SYNC_SHORT: seg_len = i_cfg.sync_short_ticks;
                S_DATA:       seg_len = raw_bit ? i_cfg.low_one_ticks : i_cfg.low_zero_ticks;
                S_CLOSE:      seg_len = i_cfg.end_low_ticks;
                default:      seg_len = i_cfg.repeat_gap_ticks;
            endcase
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_frame      = r_frame;
        n_bit_idx    = r_bit_idx;
        n_raw_half   = r_raw_half;
        n_pulse_high = r_pulse_high;
        n_tick       = r_tick;
        n_repeats    = r_repeats;
        n_level      = r_level;
        n_res        = r_res;
        if (i_step) begin
            if (i_item.func == FUNC_START) begin
                if (r_phase == S_IDLE && i_item.repeat_count != '0) begin
                    n_frame      = load_frame;
                    n_repeats    = i_item.repeat_count;
                    n_phase      = S_SYNC_LONG;
                    n_pulse_high = 1'b1;
                    n_bit_idx    = '0;
                    n_raw_half   = 1'b0;
                    n_tick       = '0;
                end
                n_res.pin_level = r_level;
                n_res.busy_res  = (n_phase != S_IDLE);
            end else if (r_phase == S_IDLE) begin
                n_level         = 1'b0;
                n_res.pin_level = 1'b0;
                n_res.busy_res  = 1'b0;
            end else begin
                n_level         = r_pulse_high;
                n_res.pin_level = r_pulse_high;
                n_res.busy_res  = 1'b1;
                n_tick          = tick_inc;
                if (tick_inc >= seg_len || tick_inc == '0) begin
                    n_tick = '0;
                    if (r_pulse_high) begin
                        n_pulse_high = 1'b0;
                    end else begin
                        unique case (r_phase)
                            S_SYNC_LONG: begin
                                n_phase      = S_SYNC_SHORT;
                                n_pulse_high = 1'b1;
                            end
                            S_SYNC_SHORT: begin
                                n_phase      = S_DATA;
                                n_bit_idx    = '0;
                                n_raw_half   = 1'b0;
                                n_pulse_high = 1'b1;
                            end
                            S_DATA: begin
                                n_pulse_high = 1'b1;
                                if (!r_raw_half) begin
                                    n_raw_half = 1'b1;
                                end else begin
                                    n_raw_half = 1'b0;
                                    n_bit_idx  = bit_inc;
                                    if (bit_inc >= BIX_W'(FRAME_BITS)) begin
                                        n_phase = S_CLOSE;
                                    end
                                end
                            end
                            S_CLOSE: begin
                                if (i_cfg.repeat_gap_ticks != '0) begin
                                    n_phase = S_GAP;
                                end else begin
                                    n_repeats    = rep_dec;
                                    n_phase      = (rep_dec != '0) ? S_SYNC_LONG : S_IDLE;
                                    n_pulse_high = (rep_dec != '0);
                                end
                            end
                            default: begin
                                n_repeats    = rep_dec;
                                n_phase      = (rep_dec != '0) ? S_SYNC_LONG : S_IDLE;
                                n_pulse_high = (rep_dec != '0);
                            end
                        endcase
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= S_IDLE;
            r_frame      <= '0;
            r_bit_idx    <= '0;
            r_raw_half   <= 1'b0;
            r_pulse_high <= 1'b0;
            r_tick       <= '0;
            r_repeats    <= '0;
            r_level      <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_frame      <= n_frame;
            r_bit_idx    <= n_bit_idx;
            r_raw_half   <= n_raw_half;
            r_pulse_high <= n_pulse_high;
            r_tick       <= n_tick;
            r_repeats    <= n_repeats;
            r_level      <= n_level;
        end
        r_res <= n_res;
    end

    assign o_res = r_res;

endmodule

// ===== hdl/rf_remote_pulse_frame_encoder.sv =====
// rf_remote_pulse_frame_encoder: top level of the OOK pulse frame encoder.
// Depends on rfe_pkg, rfe_cfg_regs and rfe_seq.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+----------------------------
//   in      | sink      | i_in_valid / o_in_stall    | i_in  (rfe_pkg::t_in_item)
//   out     | source    | o_out_valid / i_out_stall  | o_out (rfe_pkg::t_out_item)
//   cfg     | sink      | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// Every item (tick or start) gives exactly one result item. An item is held
// in the input register, is processed by the sequencer on its way into
// the result register, and is offered from there. With no output stall an
// item is taken every cycle. Reset is synchronous, active low, and loads the
// register defaults. A stalled result holds while the input register still
// takes one more item; after that the input stalls.
module rf_remote_pulse_frame_encoder #(
    parameter int unsigned ID_BITS   = 26,
    parameter int unsigned UNIT_BITS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  rfe_pkg::t_in_item             i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output rfe_pkg::t_out_item            o_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rfe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rfe_pkg::TICK_W-1:0]    i_cfg_data
);
    import rfe_pkg::*;

    t_in_item r_in;
    logic     r_in_vld;
    logic     r_out_vld;
    logic     in_acc;
    logic     step;
    t_cfg     cfg;

    // advance the input item into the result register whenever that slot is
    // empty or its item is taken this cycle
    assign step        = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall  = r_in_vld && !step;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;
    // the user must write registers only while idle; the block does not enforce it, so always take the write
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_in_vld <= 1'b1;
            end else if (step) begin
                r_in_vld <= 1'b0;
            end
            if (step) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
        // hold the payload until a new item is accepted
        if (in_acc) begin
            r_in <= i_in;
        end
    end

    rfe_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    rfe_seq #(
        .ID_BITS   (ID_BITS),
        .UNIT_BITS (UNIT_BITS)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_res   (o_out)
    );

endmodule
